// ===== src/slsa_pkg.sv =====
package slsa_pkg;

  localparam int unsigned MaxTypes = 16;
  localparam int unsigned TypeW    = $clog2(MaxTypes);
  localparam int unsigned NumW     = 5;
  localparam int unsigned AddrW    = 2 * TypeW + 1;
  localparam int unsigned RamDepth = MaxTypes * MaxTypes * 2;
  localparam int unsigned PosW     = 31;
  localparam int unsigned PmagW    = 47;

  localparam logic [NumW-1:0] PrevNone = '1;

  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_POS  = 1'b1
  } func_e;

  typedef enum logic [0:0] {
    KIND_SEG = 1'b0,
    KIND_LEN = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_TYPE,
    ST_RD,
    ST_MUL,
    ST_SCALE,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    func_e             func;
    logic              first;
    logic [TypeW-1:0]  segment_id;
    logic [TypeW-1:0]  load_type;
    kind_e             load_kind;
    logic [31:0]       loss_value;
    logic [15:0]       mask;
    logic [PosW-1:0]   position;
  } cmd_t;

  typedef struct packed {
    logic [TypeW-1:0] res_type;
    logic [63:0]      accum_loss;
    logic             last;
  } res_t;

endpackage

// ===== src/segment_loss_suffix_accumulator_top.sv =====
// Loss table words (func 0) are written into a 512-word table and produce no result.
// A position item (func 1) yields one result per segment type, for num_types clamped
// to 1..16, the final one marked by last_o. When the item's segment id is below that
// count, each type takes one pass through a shared four-stage unit (read, mask product,
// scale, saturating add), two when the segment id changes; else no pass is made. One
// state picks the type and one hands over the result, which waits while the result
// register is not yet popped. A two-entry queue at the input and a result register at
// the output let both sides stall on their own.
module segment_loss_suffix_accumulator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [slsa_pkg::NumW-1:0]  cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  logic                       func_i,
  input  logic                       first_i,
  input  logic [3:0]                 segment_id_i,
  input  logic [3:0]                 load_type_i,
  input  logic                       load_kind_i,
  input  logic signed [31:0]         loss_value_i,
  input  logic [15:0]                mask_i,
  input  logic [30:0]                position_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [3:0]                 seg_type_o,
  output logic signed [63:0]         accum_loss_o,
  output logic                       last_o
);

  logic [slsa_pkg::NumW-1:0] num_types_q;
  slsa_pkg::cmd_t            in_cmd, q_cmd;
  logic                      q_valid, q_pop;
  slsa_pkg::res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_types_q <= slsa_pkg::NumW'(1);
    end else if (cfg_we_i) begin
      num_types_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    in_cmd.func       = slsa_pkg::func_e'(func_i);
    in_cmd.first      = first_i;
    in_cmd.segment_id = segment_id_i;
    in_cmd.load_type  = load_type_i;
    in_cmd.load_kind  = slsa_pkg::kind_e'(load_kind_i);
    in_cmd.loss_value = loss_value_i;
    in_cmd.mask       = mask_i;
    in_cmd.position   = position_i;
  end

  slsa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .cmd_i      (in_cmd),
    .cmd_valid_o(q_valid),
    .cmd_o      (q_cmd),
    .cmd_pop_i  (q_pop)
  );

  slsa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .num_types_i(num_types_q),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res)
  );

  assign seg_type_o   = res.res_type;
  assign accum_loss_o = res.accum_loss;
  assign last_o       = res.last;

endmodule

// ===== src/slsa_ram.sv =====
module slsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== src/slsa_front.sv =====
module slsa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  slsa_pkg::cmd_t      cmd_i,
  output logic                cmd_valid_o,
  output slsa_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  // two-entry queue between the input side and the sequencer
  slsa_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/slsa_back.sv =====
module slsa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [slsa_pkg::NumW-1:0]  num_types_i,
  input  logic                       cmd_valid_i,
  input  slsa_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       empty,
  input  logic                       pop,
  output slsa_pkg::res_t             res_o
);

  localparam int unsigned TW = slsa_pkg::TypeW;
  localparam int unsigned NW = slsa_pkg::NumW;
  localparam int unsigned PW = slsa_pkg::PosW;
  localparam int unsigned MW = slsa_pkg::PmagW;

  slsa_pkg::state_e state_q, state_d;

  slsa_pkg::cmd_t   cur_q, cur_d;
  logic [NW-1:0]    n_q, n_d;
  logic [TW-1:0]    t_q, t_d;
  slsa_pkg::kind_e  k_q, k_d;
  logic             changed_q, changed_d;
  logic             dneg_q, dneg_d;
  logic [PW-1:0]    dmag_q, dmag_d;
  logic [NW-1:0]    prev_id_q, prev_id_d;
  logic [PW-1:0]    prev_pos_q, prev_pos_d;
  logic [63:0]      sum_q [slsa_pkg::MaxTypes];
  logic             sum_clr, sum_we;
  logic [63:0]      sum_wdata;
  logic             out_valid_q, out_valid_d;
  slsa_pkg::res_t   out_q, out_d;

  // datapath registers
  logic [MW-1:0]    pmag_q;
  logic             pneg_q;
  logic [62:0]      plo_q;
  logic [45:0]      phi_q;

  logic                          ram_we;
  logic [slsa_pkg::AddrW-1:0]    ram_addr;
  logic [31:0]                   ram_rdata;

  slsa_ram #(
    .Width(32),
    .Depth(slsa_pkg::RamDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(cmd_i.loss_value),
    .rdata_o(ram_rdata)
  );

  // effective type count, clamped to 1..MaxTypes
  logic [NW-1:0] n_eff;
  always_comb begin
    priority if (num_types_i == '0) begin
      n_eff = NW'(1);
    end else if (num_types_i > NW'(slsa_pkg::MaxTypes)) begin
      n_eff = NW'(slsa_pkg::MaxTypes);
    end else begin
      n_eff = num_types_i;
    end
  end

  // distance from previous position, seen through a first item
  logic [NW-1:0] prev_id_eff;
  logic [PW-1:0] prev_pos_eff;
  logic [PW:0]   pos_diff;
  always_comb begin
    prev_id_eff  = cur_q.first ? slsa_pkg::PrevNone : prev_id_q;
    prev_pos_eff = cur_q.first ? cur_q.position : prev_pos_q;
    pos_diff     = {1'b0, prev_pos_eff} - {1'b0, cur_q.position};
  end

  // product of mask and loss word
  logic signed [48:0] prod;
  always_comb begin
    prod = 49'($signed({1'b0, cur_q.mask})) * 49'($signed(ram_rdata));
  end

  // rounding scale and saturating accumulate
  logic [63:0]        lo_part, hi_part;
  logic [64:0]        mag65;
  logic [63:0]        mag;
  logic               term_neg;
  logic signed [65:0] acc;
  always_comb begin
    lo_part  = ({1'b0, plo_q} + 64'h2000) >> 14;
    hi_part  = {phi_q, 18'd0};
    mag65    = {1'b0, hi_part} + {1'b0, lo_part};
    mag      = mag65[64] ? '1 : mag65[63:0];
    term_neg = (k_q == slsa_pkg::KIND_LEN) ? (pneg_q ^ dneg_q) : pneg_q;
    if (term_neg) begin
      acc = $signed({{2{sum_q[t_q][63]}}, sum_q[t_q]}) - $signed({2'b00, mag});
    end else begin
      acc = $signed({{2{sum_q[t_q][63]}}, sum_q[t_q]}) + $signed({2'b00, mag});
    end
    priority if (acc > $signed({3'b000, {63{1'b1}}})) begin
      sum_wdata = {1'b0, {63{1'b1}}};
    end else if (acc < $signed({3'b111, 63'd0})) begin
      sum_wdata = {1'b1, 63'd0};
    end else begin
      sum_wdata = acc[63:0];
    end
  end

  logic id_in_range;
  logic t_is_last;
  assign id_in_range = ({1'b0, cur_q.segment_id} < n_q);
  assign t_is_last   = ({1'b0, t_q} == n_q - NW'(1));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    n_d         = n_q;
    t_d         = t_q;
    k_d         = k_q;
    changed_d   = changed_q;
    dneg_d      = dneg_q;
    dmag_d      = dmag_q;
    prev_id_d   = prev_id_q;
    prev_pos_d  = prev_pos_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = {cur_q.segment_id, t_q, k_q};
    sum_clr     = 1'b0;
    sum_we      = 1'b0;

    unique case (state_q)
      slsa_pkg::ST_IDLE: begin
        ram_addr = {cmd_i.segment_id, cmd_i.load_type, cmd_i.load_kind};
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.func == slsa_pkg::FUNC_LOAD) begin
            ram_we = 1'b1;
          end else begin
            cur_d   = cmd_i;
            state_d = slsa_pkg::ST_START;
          end
        end
      end
      slsa_pkg::ST_START: begin
        sum_clr   = cur_q.first;
        changed_d = ({1'b0, cur_q.segment_id} != prev_id_eff);
        dneg_d    = pos_diff[PW];
        dmag_d    = pos_diff[PW] ? PW'(-pos_diff) : pos_diff[PW-1:0];
        n_d       = n_eff;
        t_d       = '0;
        state_d   = slsa_pkg::ST_TYPE;
      end
      slsa_pkg::ST_TYPE: begin
        k_d     = changed_q ? slsa_pkg::KIND_SEG : slsa_pkg::KIND_LEN;
        state_d = id_in_range ? slsa_pkg::ST_RD : slsa_pkg::ST_EMIT;
      end
      slsa_pkg::ST_RD: begin
        state_d = slsa_pkg::ST_MUL;
      end
      slsa_pkg::ST_MUL: begin
        state_d = slsa_pkg::ST_SCALE;
      end
      slsa_pkg::ST_SCALE: begin
        state_d = slsa_pkg::ST_ACC;
      end
      slsa_pkg::ST_ACC: begin
        sum_we = 1'b1;
        if (k_q == slsa_pkg::KIND_SEG) begin
          k_d     = slsa_pkg::KIND_LEN;
          state_d = slsa_pkg::ST_RD;
        end else begin
          state_d = slsa_pkg::ST_EMIT;
        end
      end
      slsa_pkg::ST_EMIT: begin
        if (!out_valid_q || pop) begin
          out_valid_d      = 1'b1;
          out_d.res_type   = t_q;
          out_d.accum_loss = sum_q[t_q];
          out_d.last       = t_is_last;
          if (t_is_last) begin
            prev_id_d  = {1'b0, cur_q.segment_id};
            prev_pos_d = cur_q.position;
            state_d    = slsa_pkg::ST_IDLE;
          end else begin
            t_d     = t_q + TW'(1);
            state_d = slsa_pkg::ST_TYPE;
          end
        end
      end
      default: begin
        state_d = slsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slsa_pkg::ST_IDLE;
      prev_id_q   <= slsa_pkg::PrevNone;
      prev_pos_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < slsa_pkg::MaxTypes; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      prev_id_q   <= prev_id_d;
      prev_pos_q  <= prev_pos_d;
      out_valid_q <= out_valid_d;
      if (sum_clr) begin
        for (int i = 0; i < slsa_pkg::MaxTypes; i++) begin
          sum_q[i] <= '0;
        end
      end else if (sum_we) begin
        sum_q[t_q] <= sum_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    n_q       <= n_d;
    t_q       <= t_d;
    k_q       <= k_d;
    changed_q <= changed_d;
    dneg_q    <= dneg_d;
    dmag_q    <= dmag_d;
    out_q     <= out_d;
    if (state_q == slsa_pkg::ST_MUL) begin
      pneg_q <= prod[48];
      pmag_q <= prod[48] ? MW'(-prod) : prod[MW-1:0];
    end
    if (state_q == slsa_pkg::ST_SCALE) begin
      // segment term scales by one, length term by the distance
      plo_q <= 63'(pmag_q[31:0]) *
               63'((k_q == slsa_pkg::KIND_LEN) ? dmag_q : PW'(1));
      phi_q <= 46'(pmag_q[MW-1:32]) *
               46'((k_q == slsa_pkg::KIND_LEN) ? dmag_q : PW'(1));
    end
  end

  assign empty = !out_valid_q;
  assign res_o = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |=> out_valid_q && $stable(out_q))
    else $error("waiting result changed before it was taken");

  a_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slsa_pkg::ST_EMIT) |-> ({1'b0, t_q} < n_q))
    else $error("type index beyond type count");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slsa_pkg::ST_EMIT) && (!out_valid_q || pop) && t_is_last
    |=> state_q == slsa_pkg::ST_IDLE)
    else $error("sequencer did not return after final type");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == slsa_pkg::ST_IDLE)
    else $error("command taken while busy");

endmodule

// ===== verif/tb_segment_loss_suffix_accumulator_top.sv =====
module tb_segment_loss_suffix_accumulator_top;

  typedef struct {
    logic [3:0]         res_type;
    logic signed [63:0] accum_loss;
    logic               last;
  } loss_res_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [slsa_pkg::NumW-1:0]     cfg_wdata = '0;
  logic                          push = 1'b0;
  logic                          full;
  logic                          empty;
  logic                          pop = 1'b0;
  slsa_pkg::cmd_t                cur_cmd = '0;
  logic [3:0]                    seg_type_o;
  logic signed [63:0]            accum_loss_o;
  logic                          last_o;

  slsa_pkg::cmd_t                pending_q[$];
  loss_res_t                     expected_sums_q[$];
  int                            fail_cnt = 0;
  bit                            quiet = 1'b0;
  int                            send_gap = 0;
  int                            recv_gap = 0;

  // predictor state
  logic [31:0]                   loss_tab[slsa_pkg::RamDepth];
  logic signed [63:0]            run_sum[slsa_pkg::MaxTypes];
  logic [slsa_pkg::NumW-1:0]     last_id;
  logic [slsa_pkg::PosW-1:0]     prior_pos;
  logic [slsa_pkg::NumW-1:0]     type_count;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  segment_loss_suffix_accumulator_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .func_i       (cur_cmd.func),
    .first_i      (cur_cmd.first),
    .segment_id_i (cur_cmd.segment_id),
    .load_type_i  (cur_cmd.load_type),
    .load_kind_i  (cur_cmd.load_kind),
    .loss_value_i (cur_cmd.loss_value),
    .mask_i       (cur_cmd.mask),
    .position_i   (cur_cmd.position),
    .empty        (empty),
    .pop          (pop),
    .seg_type_o   (seg_type_o),
    .accum_loss_o (accum_loss_o),
    .last_o       (last_o)
  );

  // rounded magnitude of a*d/2^14, high part wraps as the hardware does, capped at all ones
  function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] d);
    logic [63:0] ah, al, x, hi, lo;
    ah = a >> 32;
    al = a & 64'hFFFF_FFFF;
    x  = al * d + 64'h2000;
    hi = (ah * d) << 18;
    lo = x >> 14;
    if (hi > ~64'd0 - lo) return ~64'd0;
    return hi + lo;
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] s, bit neg,
                                                 logic [63:0] m);
    logic signed [65:0] w;
    w = neg ? ($signed({{2{s[63]}}, s}) - $signed({2'b00, m}))
            : ($signed({{2{s[63]}}, s}) + $signed({2'b00, m}));
    if (w > $signed({2'b00, 64'h7FFF_FFFF_FFFF_FFFF})) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (w < $signed({2'b11, 64'h8000_0000_0000_0000})) return 64'h8000_0000_0000_0000;
    return w[63:0];
  endfunction

  function automatic void predict_sums(slsa_pkg::cmd_t c);
    int unsigned n, t, k;
    bit changed, dneg, pneg;
    longint pos_diff, p;
    logic [63:0] dmag, pmag;
    loss_res_t r;
    if (c.func == slsa_pkg::FUNC_LOAD) begin
      loss_tab[{c.segment_id, c.load_type, c.load_kind}] = c.loss_value;
      return;
    end
    n = (type_count == 0) ? 1 :
        (type_count > slsa_pkg::MaxTypes ? slsa_pkg::MaxTypes : type_count);
    if (c.first) begin
      foreach (run_sum[i]) run_sum[i] = '0;
      last_id   = slsa_pkg::PrevNone;
      prior_pos = c.position;
    end
    changed = {1'b0, c.segment_id} != last_id;
    pos_diff = longint'({1'b0, prior_pos}) - longint'({1'b0, c.position});
    dneg = pos_diff < 0;
    dmag = dneg ? -pos_diff : pos_diff;
    for (t = 0; t < n; t++) begin
      if (c.segment_id < n) begin
        for (k = 0; k < 2; k++) begin
          p = longint'({48'd0, c.mask}) *
              longint'($signed(loss_tab[{c.segment_id, t[3:0], k[0]}]));
          pneg = p < 0;
          pmag = pneg ? -p : p;
          if (k == 0) begin
            if (changed) run_sum[t] = sat_add(run_sum[t], pneg, scale_round(pmag, 64'd1));
          end else begin
            run_sum[t] = sat_add(run_sum[t], pneg != dneg, scale_round(pmag, dmag));
          end
        end
      end
      r.res_type   = t[3:0];
      r.accum_loss = run_sum[t];
      r.last       = (t + 1 == n);
      expected_sums_q.push_back(r);
    end
    last_id   = {1'b0, c.segment_id};
    prior_pos = c.position;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic nxt_push;
    if (push && !full) begin
      predict_sums(cur_cmd);
      void'(pending_q.pop_front());
    end
    nxt_push = 1'b0;
    if (send_gap > 0) begin
      send_gap <= send_gap - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      send_gap <= $urandom_range(0, 11);
    end else if (pending_q.size() > 0) begin
      nxt_push = 1'b1;
      cur_cmd <= pending_q[0];
    end
    push <= nxt_push;
  end

  // monitor
  always @(posedge clk_i) begin
    logic nxt_pop;
    loss_res_t e;
    if (pop && !empty) begin
      if (expected_sums_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_cnt++;
      end else begin
        e = expected_sums_q.pop_front();
        if (seg_type_o !== e.res_type) begin
          $error("seg_type_o expected %0d got %0d", e.res_type, seg_type_o);
          fail_cnt++;
        end
        if (accum_loss_o !== e.accum_loss) begin
          $error("accum_loss expected %0d got %0d", e.accum_loss, accum_loss_o);
          fail_cnt++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0d got %0d", e.last, last_o);
          fail_cnt++;
        end
      end
    end
    nxt_pop = 1'b1;
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      nxt_pop = 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 11);
      nxt_pop = 1'b0;
    end
    pop <= nxt_pop;
  end

  function automatic logic [31:0] rand_loss();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  task automatic add_load(int id, int ty, int kd, logic [31:0] v);
    slsa_pkg::cmd_t c;
    c = '0;
    c.func = slsa_pkg::FUNC_LOAD;
    c.segment_id = 4'(id);
    c.load_type = 4'(ty);
    c.load_kind = slsa_pkg::kind_e'(kd[0]);
    c.loss_value = v;
    c.first = 1'($urandom_range(0, 1));
    c.mask = 16'($urandom());
    c.position = 31'($urandom());
    pending_q.push_back(c);
  endtask

  task automatic add_pos(bit first, int id, logic [15:0] m, logic [30:0] p);
    slsa_pkg::cmd_t c;
    c = '0;
    c.func = slsa_pkg::FUNC_POS;
    c.first = first;
    c.segment_id = 4'(id);
    c.load_type = 4'($urandom());
    c.load_kind = slsa_pkg::kind_e'(1'($urandom_range(0, 1)));
    c.loss_value = $urandom();
    c.mask = m;
    c.position = p;
    pending_q.push_back(c);
  endtask

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(0, 4))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'h4000;
      default: return 16'($urandom());
    endcase
  endfunction

  // ids 0 and 1 read loaded rows, ids at or above the type count read nothing
  function automatic int pick_id();
    int unsigned n;
    n = (type_count == 0) ? 1 :
        (type_count > slsa_pkg::MaxTypes ? slsa_pkg::MaxTypes : type_count);
    if (n < slsa_pkg::MaxTypes && $urandom_range(0, 2) == 0) return $urandom_range(n, 15);
    return $urandom_range(0, 1);
  endfunction

  // a well-formed run of positions in non-increasing order, or a broken one
  task automatic add_run(int len, bit broken);
    logic [30:0] p;
    int id;
    p = ($urandom_range(0, 7) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 4000));
    id = pick_id();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 2) != 0) id = pick_id();
      add_pos(broken ? 1'($urandom_range(0, 1)) : (i == 0), id, rand_mask(), p);
      if (broken) p = 31'($urandom());
      else if (p > 50) p = 31'(p - $urandom_range(0, 50));
      if (!broken && $urandom_range(0, 5) == 0) add_load($urandom(), $urandom(),
                                                          $urandom(), rand_loss());
    end
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0 || push || expected_sums_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_types(logic [slsa_pkg::NumW-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    type_count = v;
  endtask

  initial begin
    logic [slsa_pkg::NumW-1:0] settings[7] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd3, 5'd16};
    foreach (loss_tab[i]) loss_tab[i] = '0;
    foreach (run_sum[i]) run_sum[i] = '0;
    last_id = slsa_pkg::PrevNone;
    prior_pos = '0;
    type_count = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // fill the rows in use so that no unwritten word is ever read
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < slsa_pkg::MaxTypes; j++)
        for (int k = 0; k < 2; k++) add_load(i, j, k, rand_loss());
    wait_drain();
    write_types(settings[0]);
    // directed: extreme words, both saturation directions, rising positions
    add_load(0, 0, slsa_pkg::KIND_SEG, 32'h8000_0000);
    add_load(0, 0, slsa_pkg::KIND_LEN, 32'h7FFF_FFFF);
    add_load(1, 0, slsa_pkg::KIND_LEN, 32'h8000_0000);
    add_pos(1'b1, 0, 16'hFFFF, 31'h7FFF_FFFF);
    add_pos(1'b0, 0, 16'hFFFF, 31'd0);
    add_pos(1'b0, 0, 16'hFFFF, 31'h7FFF_FFFF);
    add_pos(1'b1, 1, 16'hFFFF, 31'h7FFF_FFFF);
    add_pos(1'b0, 1, 16'hFFFF, 31'd0);
    add_pos(1'b0, 1, 16'h0000, 31'd5);
    add_pos(1'b0, 1, 16'h4000, 31'd10);
    add_pos(1'b1, 0, 16'h0001, 31'd100);
    add_pos(1'b0, 0, 16'h0001, 31'd90);
    add_pos(1'b0, 1, 16'h8000, 31'd90);
    add_pos(1'b0, 0, 16'h1234, 31'd7);
    wait_drain();
    for (int ph = 1; ph < 7; ph++) begin
      write_types(settings[ph]);
      if (ph == 6) quiet = 1'b1;
      for (int r = 0; r < 3; r++) add_run($urandom_range(3, 5), $urandom_range(0, 4) == 0);
      wait_drain();
    end
    if (fail_cnt == 0) begin
      $display("segment_loss_suffix_accumulator_top regression: pass");
    end else begin
      $display("segment_loss_suffix_accumulator_top regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("segment_loss_suffix_accumulator_top regression: fail");
    $finish;
  end

endmodule

// ===== segment_loss_suffix_accumulator_top.f =====
src/slsa_pkg.sv
src/slsa_ram.sv
src/slsa_front.sv
src/slsa_back.sv
src/segment_loss_suffix_accumulator_top.sv
verif/tb_segment_loss_suffix_accumulator_top.sv
